// ----- sv/binary_min_heap_queue_defines.svh -----
// Assertion macros shared by the binary min-heap queue RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef BINARY_MIN_HEAP_QUEUE_DEFINES_SVH
`define BINARY_MIN_HEAP_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BMHQ_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define BMHQ_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/bmhq_pkg.sv -----
// Types and constants for the binary min-heap queue.
// No dependencies; used by scoped names from the top level.
package bmhq_pkg;

  localparam logic CMD_INSERT  = 1'b0;
  localparam logic CMD_EXTRACT = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic               command;
    logic signed [31:0] item_value;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    logic [1:0]         status;
    logic [8:0]         fill_count;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_DN_ROOT,
    S_DN_LAST,
    S_DN_RDL,
    S_DN_RDR,
    S_DN_SEL,
    S_DN_CMP,
    S_DONE
  } state_t;

endpackage

// ----- sv/bmhq_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the heap slots.
module bmhq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/bmhq_cmp.sv -----
// Shared signed 32-bit less-than unit used by every heap compare.
// No dependencies.
module bmhq_cmp (
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic               lt
);

  // Strict compare, so equal values never cause a swap.
  assign lt = a < b;

endmodule

// ----- sv/binary_min_heap_queue.sv -----
// Binary min-heap priority queue: top level with the sequencer and datapath.
// Depends on bmhq_pkg, bmhq_ram, bmhq_cmp and binary_min_heap_queue_defines.svh.
//
// Usage: the command channel (cmd_valid, cmd_ready, cmd) carries an insert of a
// signed value or an extract of the minimum. The response channel (rsp_valid,
// rsp_ready, rsp) returns exactly one transfer per command: the extracted value
// (zero otherwise), a status of ok, empty or full, and the element count after
// the command. At most HEAP_SLOTS-1 values are held, in RAM slots 1 and up.
// An insert rises level by level, reading the parent and comparing it with the
// new value, and stops at the root or at a parent that is not greater. An
// extract reads the root and the last element, then sinks that element: each
// level reads the left child and any right child, picks the smaller with the
// single shared comparator and compares it with the moved element. Rejected
// commands (full or empty) go straight to the done state, which raises
// rsp_valid once the output register is free. cmd_ready is high only while
// idle, so the next command can transfer in the same cycle that rsp_valid
// rises. Reset empties the heap at once; the RAM is not cleared and needs no
// pass. If the receiver stalls, the response waits in the output register;
// one more command is taken and worked on, and it then holds in its last
// state, with cmd_ready low, until the output register is free.
module binary_min_heap_queue #(
  parameter int HEAP_SLOTS = 512
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  bmhq_pkg::cmd_t  cmd,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output bmhq_pkg::rsp_t  rsp
);

`include "binary_min_heap_queue_defines.svh"

  localparam int AW = $clog2(HEAP_SLOTS);
  localparam int CW = AW + 1;
  localparam logic [AW-1:0] CNT_MAX = AW'(HEAP_SLOTS - 1);
  localparam logic [AW-1:0] ROOT    = AW'(1);

  bmhq_pkg::state_t state, state_next;

  // Element count, sift position and the value being moved.
  logic [AW-1:0]      count;
  logic [AW-1:0]      pos;
  logic [AW-1:0]      pick;
  logic signed [31:0] cur;
  logic signed [31:0] pick_val;
  logic signed [31:0] res_value;
  logic [1:0]         res_status;

  logic [CW-1:0] left_idx;
  logic [CW-1:0] right_idx;
  logic          left_out;
  logic          right_in;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [31:0]   rd_data;

  logic signed [31:0] cmp_a;
  logic signed [31:0] cmp_b;
  logic               cmp_lt;

  logic rsp_free;

  assign left_idx  = {pos, 1'b0};
  assign right_idx = {pos, 1'b1};
  assign left_out  = left_idx > {1'b0, count};
  assign right_in  = right_idx <= {1'b0, count};
  assign rsp_free  = !rsp_valid || rsp_ready;
  assign cmd_ready = (state == bmhq_pkg::S_IDLE);

  bmhq_ram #(
    .WIDTH(32),
    .DEPTH(HEAP_SLOTS)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  bmhq_cmp u_cmp (
    .a (cmp_a),
    .b (cmp_b),
    .lt(cmp_lt)
  );

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      bmhq_pkg::S_IDLE: begin
        if (cmd_valid) begin
          if (cmd.command == bmhq_pkg::CMD_EXTRACT) begin
            state_next = (count == '0) ? bmhq_pkg::S_DONE : bmhq_pkg::S_DN_ROOT;
          end else begin
            state_next = (count == CNT_MAX) ? bmhq_pkg::S_DONE : bmhq_pkg::S_UP_RD;
          end
        end
      end
      bmhq_pkg::S_UP_RD:   state_next = (pos == ROOT) ? bmhq_pkg::S_DONE : bmhq_pkg::S_UP_CMP;
      bmhq_pkg::S_UP_CMP:  state_next = cmp_lt ? bmhq_pkg::S_UP_RD : bmhq_pkg::S_DONE;
      bmhq_pkg::S_DN_ROOT: state_next = bmhq_pkg::S_DN_LAST;
      bmhq_pkg::S_DN_LAST: state_next = bmhq_pkg::S_DN_RDL;
      bmhq_pkg::S_DN_RDL:  state_next = left_out ? bmhq_pkg::S_DONE : bmhq_pkg::S_DN_RDR;
      bmhq_pkg::S_DN_RDR:  state_next = right_in ? bmhq_pkg::S_DN_SEL : bmhq_pkg::S_DN_CMP;
      bmhq_pkg::S_DN_SEL:  state_next = bmhq_pkg::S_DN_CMP;
      bmhq_pkg::S_DN_CMP:  state_next = cmp_lt ? bmhq_pkg::S_DN_RDL : bmhq_pkg::S_DONE;
      bmhq_pkg::S_DONE:    state_next = rsp_free ? bmhq_pkg::S_IDLE : bmhq_pkg::S_DONE;
      default:             state_next = bmhq_pkg::S_IDLE;
    endcase
  end

  // RAM and comparator controls. The moving value stays in cur, so each
  // level writes only the slot it leaves; the final write places cur.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos;
    wr_data = cur;
    rd_en   = 1'b0;
    rd_addr = ROOT;
    cmp_a   = cur;
    cmp_b   = rd_data;
    case (state)
      bmhq_pkg::S_IDLE: begin
        rd_en = cmd_valid && (cmd.command == bmhq_pkg::CMD_EXTRACT);
      end
      bmhq_pkg::S_UP_RD: begin
        rd_en   = (pos != ROOT);
        rd_addr = pos >> 1;
        wr_en   = (pos == ROOT);
      end
      bmhq_pkg::S_UP_CMP: begin
        wr_en   = 1'b1;
        wr_data = cmp_lt ? rd_data : cur;
      end
      bmhq_pkg::S_DN_ROOT: begin
        rd_en   = 1'b1;
        rd_addr = count;
      end
      bmhq_pkg::S_DN_RDL: begin
        wr_en   = left_out;
        rd_en   = !left_out;
        rd_addr = left_idx[AW-1:0];
      end
      bmhq_pkg::S_DN_RDR: begin
        rd_en   = right_in;
        rd_addr = right_idx[AW-1:0];
      end
      bmhq_pkg::S_DN_SEL: begin
        cmp_a = rd_data;
        cmp_b = pick_val;
      end
      bmhq_pkg::S_DN_CMP: begin
        cmp_a   = pick_val;
        cmp_b   = cur;
        wr_en   = 1'b1;
        wr_data = cmp_lt ? pick_val : cur;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bmhq_pkg::S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      // In the done state a free output register is reloaded below instead.
      if (rsp_valid && rsp_ready && state != bmhq_pkg::S_DONE) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        bmhq_pkg::S_IDLE: begin
          if (cmd_valid) begin
            res_value <= '0;
            if (cmd.command == bmhq_pkg::CMD_EXTRACT) begin
              res_status <= (count == '0) ? bmhq_pkg::STATUS_EMPTY : bmhq_pkg::STATUS_OK;
            end else if (count == CNT_MAX) begin
              res_status <= bmhq_pkg::STATUS_FULL;
            end else begin
              res_status <= bmhq_pkg::STATUS_OK;
              count      <= AW'(count + AW'(1));
              pos        <= AW'(count + AW'(1));
              cur        <= cmd.item_value;
            end
          end
        end
        bmhq_pkg::S_UP_CMP: begin
          if (cmp_lt) begin
            pos <= pos >> 1;
          end
        end
        bmhq_pkg::S_DN_ROOT: begin
          res_value <= rd_data;
        end
        bmhq_pkg::S_DN_LAST: begin
          cur   <= rd_data;
          count <= AW'(count - AW'(1));
          pos   <= ROOT;
        end
        bmhq_pkg::S_DN_RDR: begin
          pick_val <= rd_data;
          pick     <= left_idx[AW-1:0];
        end
        bmhq_pkg::S_DN_SEL: begin
          if (cmp_lt) begin
            pick_val <= rd_data;
            pick     <= right_idx[AW-1:0];
          end
        end
        bmhq_pkg::S_DN_CMP: begin
          if (cmp_lt) begin
            pos <= pick;
          end
        end
        bmhq_pkg::S_DONE: begin
          if (rsp_free) begin
            rsp_valid      <= 1'b1;
            rsp.out_value  <= res_value;
            rsp.status     <= res_status;
            rsp.fill_count <= 9'(count);
          end
        end
        default: begin
        end
      endcase
    end
  end

  `BMHQ_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CNT_MAX, "element count overflow")

  `BMHQ_ASSERT_NOW(a_write_states, clk, rst, wr_en,
    state == bmhq_pkg::S_UP_RD || state == bmhq_pkg::S_UP_CMP ||
    state == bmhq_pkg::S_DN_RDL || state == bmhq_pkg::S_DN_CMP,
    "heap write outside a sift step")

  `BMHQ_ASSERT_NEXT(a_full_reject, clk, rst,
    cmd_valid && cmd_ready && cmd.command == bmhq_pkg::CMD_INSERT && count == CNT_MAX,
    state == bmhq_pkg::S_DONE && res_status == bmhq_pkg::STATUS_FULL && $stable(count),
    "insert into a full heap not rejected")

  `BMHQ_ASSERT_NOW(a_pos_nonzero, clk, rst,
    state == bmhq_pkg::S_UP_RD || state == bmhq_pkg::S_UP_CMP ||
    state == bmhq_pkg::S_DN_RDL || state == bmhq_pkg::S_DN_CMP,
    pos != '0, "sift position left the heap")

endmodule
